// ===== sv/sdus_pkg.sv =====
// ----------------------------------------------------------------------------
// sdus_pkg
// Shared constants, types and the segment encoding table for the display
// update sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdus_pkg;

  localparam int DIGITS          = 4;
  localparam int STEPS_PER_DIGIT = 8;
  localparam int NUM_CHARS       = 4;
  localparam int SUB_W           = $clog2(STEPS_PER_DIGIT);
  localparam int SEQ_END         = DIGITS * STEPS_PER_DIGIT;
  localparam int STEP_W          = $clog2(SEQ_END + 1);
  localparam int IDX_W           = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int QCNT_W          = $clog2(QDEPTH + 1);

  // item kinds
  localparam logic [1:0] OP_TICK         = 2'd0;
  localparam logic [1:0] OP_SET_NORMAL   = 2'd1;
  localparam logic [1:0] OP_SET_OVERRIDE = 2'd2;
  localparam logic [1:0] OP_BRIGHTNESS   = 2'd3;

  // bus actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // one queued result: a single action or a start/write/stop triple
  typedef struct packed {
    logic       triple;
    logic [1:0] action;
    logic [7:0] data;
  } res_t;

  function automatic logic [7:0] seg_code(input logic [7:0] ch);
    logic [7:0] code;
    case (ch) inside
      "0", "o", "O": code = 8'h3f;
      "1", "i", "I": code = 8'h06;
      "2":           code = 8'h5b;
      "3":           code = 8'h4f;
      "4":           code = 8'h66;
      "5", "s", "S": code = 8'h6d;
      "6":           code = 8'h7d;
      "7":           code = 8'h07;
      "8", "B":      code = 8'h7f;
      "9":           code = 8'h6f;
      "a", "A", "R": code = 8'h77;
      "b":           code = 8'h7c;
      "c", "C":      code = 8'h39;
      "d", "D":      code = 8'h5e;
      "e", "E":      code = 8'h79;
      "f", "F":      code = 8'h71;
      "l", "L":      code = 8'h38;
      "p", "P":      code = 8'h73;
      default:       code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== sv/segment_display_update_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// segment_display_update_sequencer_unit
// Four-digit two-wire display update sequencer: message encoding, override
// timing, per-digit bus sequence and brightness commands.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream (op in s_tuser) and are taken one per cycle
// whenever the result queue is not full; each item is fully evaluated in the
// cycle it is accepted, with one lane per digit encoding characters and
// checking the staged message for changes.
// A tick with nonzero time takes one step of the eight-step-per-digit
// sequence unless it is done and nothing is pending, giving zero or one bus
// action; a brightness item yields a start, write, stop run of three
// transfers; set items yield nothing. Results leave on the m_ stream (action
// in m_tuser, byte in m_tdata, m_tlast on the final transfer of an item) in
// the cycle after acceptance at the earliest. The four-entry result queue
// sets the back-pressure: while m_tready is low it fills and s_tready drops
// once four items with results are waiting. Sustained rate is one item per
// cycle while m_tready stays high and no brightness run holds the output.
// Reset (rst, synchronous) clears all messages, the sequence, the times and
// the queue, and loads the register defaults. Registers are written through
// the APB port at byte address 4*index.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_display_update_sequencer_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  // stream in
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // time_us[31:0], char0[39:32], char1[47:40], char2[55:48], char3[63:56],
  // char_count[66:64], colon_on[67], duration_us[99:68],
  // brightness_level[107:100], zero pad[111:108]
  input  wire logic [111:0] s_tdata,
  input  wire logic   [1:0] s_tuser,  // op[1:0]
  // stream out
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic        [7:0] m_tdata,  // bus_byte[7:0]
  output logic        [1:0] m_tuser,  // bus_action[1:0]
  output logic              m_tlast,  // last_of_run
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic   [4:0] paddr,
  input  wire logic  [31:0] pwdata,
  output logic       [31:0] prdata,
  output logic              pready
);

  localparam logic [2:0] REG_FIXED_ADDR = 3'd0;
  localparam logic [2:0] REG_SET_ADDR   = 3'd1;
  localparam logic [2:0] REG_BRIGHT     = 3'd2;
  localparam logic [2:0] REG_COLON      = 3'd3;
  localparam logic [2:0] REG_MAX_BRIGHT = 3'd4;
  localparam logic [2:0] REG_MIN_BRIGHT = 3'd5;

  localparam int D       = sdus_pkg::DIGITS;
  localparam int SW      = sdus_pkg::STEP_W;
  localparam int IDX_W_L = sdus_pkg::IDX_W;

  // configuration registers
  logic [7:0] fixed_addr_cmd;
  logic [7:0] set_addr_cmd;
  logic [7:0] bright_cmd;
  logic [7:0] colon_flag;
  logic [2:0] max_bright;
  logic [2:0] min_bright;
  logic [2:0] cfg_idx;
  logic       cfg_wr;

  // block state
  logic [D-1:0][7:0] normal_msg, normal_msg_next;
  logic [D-1:0][7:0] override_msg, override_msg_next;
  logic [D-1:0][7:0] staged_msg, staged_msg_next;
  logic              pending, pending_next;
  logic [SW-1:0]     step, step_next;
  logic [31:0]       last_time, last_time_next;
  logic [31:0]       ov_start, ov_start_next;
  logic [31:0]       ov_life, ov_life_next;

  // item fields
  logic [1:0]  op;
  logic [31:0] time_us;
  logic [7:0]  chars [sdus_pkg::NUM_CHARS];
  logic [2:0]  char_count;
  logic        colon_on;
  logic [31:0] duration_us;
  logic [7:0]  bright_level;

  logic              s_fire;
  logic              q_full;
  logic              emit;
  sdus_pkg::res_t    res;
  logic [D-1:0][7:0] codes;
  logic [D-1:0][7:0] src_msg;
  logic [D-1:0]      diffs;
  logic [2:0]        cnt_clamp;
  logic              pend_mid;
  logic              seq_done;
  logic [sdus_pkg::SUB_W-1:0] sub_eff;
  logic [IDX_W_L-1:0]         idx;
  logic [7:0]        lvl;
  logic              restage;

  assign op           = s_tuser;
  assign time_us      = s_tdata[31:0];
  assign chars[0]     = s_tdata[39:32];
  assign chars[1]     = s_tdata[47:40];
  assign chars[2]     = s_tdata[55:48];
  assign chars[3]     = s_tdata[63:56];
  assign char_count   = s_tdata[66:64];
  assign colon_on     = s_tdata[67];
  assign duration_us  = s_tdata[99:68];
  assign bright_level = s_tdata[107:100];

  assign s_tready = !q_full;
  assign s_fire   = s_tvalid && s_tready;

  // digit count saturates at four and at the digit count
  always_comb begin
    cnt_clamp = (char_count > 3'd4) ? 3'd4 : char_count;
    if (int'(cnt_clamp) > D) begin
      cnt_clamp = 3'(D);
    end
  end

  // digit lanes
  for (genvar i = 0; i < D; i++) begin : g_lane
    logic [7:0] lane_ch;
    logic       lane_act;
    if (i < sdus_pkg::NUM_CHARS) begin : g_char
      assign lane_ch  = chars[i];
      assign lane_act = (int'(cnt_clamp) > i);
    end else begin : g_blank
      assign lane_ch  = 8'h00;
      assign lane_act = 1'b0;
    end
    sdus_lane u_lane (
      .ch          (lane_ch),
      .active      (lane_act),
      .colon_on    (colon_on),
      .colon_flag  (colon_flag),
      .code        (codes[i]),
      .staged_byte (staged_msg[i]),
      .src_byte    (src_msg[i]),
      .diff        (diffs[i])
    );
  end

  assign seq_done = (step >= SW'(sdus_pkg::SEQ_END));
  assign sub_eff  = seq_done ? '0 : step[sdus_pkg::SUB_W-1:0];
  assign idx      = IDX_W_L'(step >> sdus_pkg::SUB_W);

  // brightness clamp
  always_comb begin
    lvl = bright_level;
    if (bright_level > {5'd0, max_bright}) begin
      lvl = {5'd0, max_bright};
    end else if (bright_level < {5'd0, min_bright}) begin
      lvl = {5'd0, min_bright};
    end
  end

  // sequence step, message update and restage
  always_comb begin
    step_next         = step;
    pend_mid          = pending;
    last_time_next    = last_time;
    normal_msg_next   = normal_msg;
    override_msg_next = override_msg;
    ov_start_next     = ov_start;
    ov_life_next      = ov_life;
    emit              = 1'b0;
    res               = '0;
    restage           = 1'b1;

    case (op)
      sdus_pkg::OP_TICK: begin
        if (time_us != 32'd0) begin
          last_time_next = time_us;
          if (!(seq_done && !pending)) begin
            step_next = step + 1'b1;
            case (sub_eff)
              3'd0: begin
                if (pending) begin
                  step_next = SW'(1);
                  pend_mid  = 1'b0;
                end
              end
              3'd1, 3'd4: begin
                emit = 1'b1;
                res  = '{triple: 1'b0, action: sdus_pkg::ACT_START, data: 8'h00};
              end
              3'd2: begin
                emit = 1'b1;
                res  = '{triple: 1'b0, action: sdus_pkg::ACT_WRITE, data: fixed_addr_cmd};
              end
              3'd5: begin
                emit = 1'b1;
                res  = '{triple: 1'b0, action: sdus_pkg::ACT_WRITE,
                         data: 8'(step >> sdus_pkg::SUB_W) | set_addr_cmd};
              end
              3'd6: begin
                emit = 1'b1;
                res  = '{triple: 1'b0, action: sdus_pkg::ACT_WRITE,
                         data: staged_msg[idx]};
              end
              default: begin
                emit = 1'b1;
                res  = '{triple: 1'b0, action: sdus_pkg::ACT_STOP, data: 8'h00};
              end
            endcase
          end
        end
      end
      sdus_pkg::OP_SET_NORMAL: begin
        normal_msg_next = codes;
      end
      sdus_pkg::OP_SET_OVERRIDE: begin
        override_msg_next = codes;
        ov_life_next      = duration_us;
        ov_start_next     = last_time;
      end
      default: begin
        restage = 1'b0;
        emit    = 1'b1;
        res     = '{triple: 1'b1, action: sdus_pkg::ACT_WRITE, data: bright_cmd + lvl};
      end
    endcase

    src_msg = normal_msg_next;
    if (restage && ov_start_next != 32'd0) begin
      if ((last_time_next - ov_start_next) > ov_life_next) begin
        ov_start_next = 32'd0;
        ov_life_next  = 32'd0;
      end else begin
        src_msg = override_msg_next;
      end
    end

    staged_msg_next = restage ? src_msg : staged_msg;
    pending_next    = pend_mid | (restage & (|diffs));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_msg   <= '0;
      override_msg <= '0;
      staged_msg   <= '0;
      pending      <= 1'b0;
      step         <= '0;
      last_time    <= '0;
      ov_start     <= '0;
      ov_life      <= '0;
    end else if (s_fire) begin
      normal_msg   <= normal_msg_next;
      override_msg <= override_msg_next;
      staged_msg   <= staged_msg_next;
      pending      <= pending_next;
      step         <= step_next;
      last_time    <= last_time_next;
      ov_start     <= ov_start_next;
      ov_life      <= ov_life_next;
    end
  end

  sdus_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (s_fire && emit),
    .push_res (res),
    .full     (q_full),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_addr_cmd <= 8'h44;
      set_addr_cmd   <= 8'hc0;
      bright_cmd     <= 8'h88;
      colon_flag     <= 8'h80;
      max_bright     <= 3'd7;
      min_bright     <= 3'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FIXED_ADDR: fixed_addr_cmd <= pwdata[7:0];
        REG_SET_ADDR:   set_addr_cmd   <= pwdata[7:0];
        REG_BRIGHT:     bright_cmd     <= pwdata[7:0];
        REG_COLON:      colon_flag     <= pwdata[7:0];
        REG_MAX_BRIGHT: max_bright     <= pwdata[2:0];
        REG_MIN_BRIGHT: min_bright     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FIXED_ADDR: prdata = {24'd0, fixed_addr_cmd};
      REG_SET_ADDR:   prdata = {24'd0, set_addr_cmd};
      REG_BRIGHT:     prdata = {24'd0, bright_cmd};
      REG_COLON:      prdata = {24'd0, colon_flag};
      REG_MAX_BRIGHT: prdata = {29'd0, max_bright};
      REG_MIN_BRIGHT: prdata = {29'd0, min_bright};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/sdus_lane.sv =====
// ----------------------------------------------------------------------------
// sdus_lane
// One digit lane: encodes a character to its segment code and flags a
// difference between the staged digit and its new source.
// ----------------------------------------------------------------------------
`default_nettype none

module sdus_lane (
  input  wire logic [7:0] ch,
  input  wire logic       active,
  input  wire logic       colon_on,
  input  wire logic [7:0] colon_flag,
  output logic      [7:0] code,
  input  wire logic [7:0] staged_byte,
  input  wire logic [7:0] src_byte,
  output logic            diff
);

  always_comb begin
    code = 8'h00;
    if (active) begin
      code = sdus_pkg::seg_code(ch) + (colon_on ? colon_flag : 8'h00);
    end
  end

  assign diff = (staged_byte != src_byte);

endmodule

`default_nettype wire

// ===== sv/sdus_outq.sv =====
// ----------------------------------------------------------------------------
// sdus_outq
// Result queue and output serializer: holds queued results and expands a
// brightness triple into start, write and stop transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module sdus_outq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sdus_pkg::res_t push_res,
  output logic               full,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic         [7:0] m_tdata,  // bus_byte[7:0]
  output logic         [1:0] m_tuser,  // bus_action[1:0]
  output logic               m_tlast
);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_WRITE = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;

  sdus_pkg::res_t                     mem [sdus_pkg::QDEPTH];
  logic [sdus_pkg::QPTR_W-1:0]        wr_ptr;
  logic [sdus_pkg::QPTR_W-1:0]        rd_ptr;
  logic [sdus_pkg::QCNT_W-1:0]        count;
  logic [1:0]                         phase;
  sdus_pkg::res_t                     head;
  logic                               xfer;
  logic                               pop;

  assign head     = mem[rd_ptr];
  assign m_tvalid = (count != '0);
  assign full     = (count == sdus_pkg::QCNT_W'(sdus_pkg::QDEPTH));
  assign xfer     = m_tvalid && m_tready;
  assign pop      = xfer && m_tlast;

  always_comb begin
    m_tuser = head.action;
    m_tdata = head.data;
    m_tlast = 1'b1;
    if (head.triple) begin
      case (phase)
        PH_START: begin
          m_tuser = sdus_pkg::ACT_START;
          m_tdata = 8'h00;
          m_tlast = 1'b0;
        end
        PH_WRITE: begin
          m_tuser = sdus_pkg::ACT_WRITE;
          m_tlast = 1'b0;
        end
        default: begin
          m_tuser = sdus_pkg::ACT_STOP;
          m_tdata = 8'h00;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      phase  <= PH_START;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
      if (xfer) begin
        phase <= m_tlast ? PH_START : phase + 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sdus_pkg::QCNT_W'(sdus_pkg::QDEPTH))
    else $error("queue count out of range");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_START || phase == PH_WRITE || phase == PH_STOP)
    else $error("serializer phase out of range");

  a_single_phase: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !head.triple) |-> phase == PH_START)
    else $error("single result seen mid-triple");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

endmodule

`default_nettype wire
